// ===== sv/kwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// kwsc_pkg
// Types, codes and helpers shared by the keyword substitution cipher modules.
// ----------------------------------------------------------------------------
package kwsc_pkg;

    localparam int LETTERS = 26;
    localparam int IDX_W   = 5;

    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_TEXT = 2'd2;

    localparam logic [7:0] ASCII_UC_A = 8'h41;
    localparam logic [7:0] ASCII_UC_Z = 8'h5A;
    localparam logic [7:0] ASCII_LC_A = 8'h61;
    localparam logic [7:0] ASCII_LC_Z = 8'h7A;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LETTERS - 1);
    localparam logic [IDX_W:0]   FULL_CNT = (IDX_W + 1)'(LETTERS);

    typedef logic [IDX_W-1:0] letter_idx_t;

    typedef struct packed {
        logic        is_letter;
        logic        lower;
        letter_idx_t idx;
    } letter_info_t;

    // controller -> datapath
    typedef struct packed {
        logic        key_byte;
        logic        end_key;
        logic        text;
        logic        fill_step;
        logic        inv_step;
        logic        ident_step;
        logic        clear_build;
        letter_idx_t sweep_idx;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic key_bad;
        logic out_free;
    } dp_status_t;

    function automatic letter_info_t letter_decode(input logic [7:0] c);
        letter_info_t r;
        r = '0;
        if (c >= ASCII_UC_A && c <= ASCII_UC_Z) begin
            r.is_letter = 1'b1;
            r.idx       = IDX_W'(c - ASCII_UC_A);
        end else if (c >= ASCII_LC_A && c <= ASCII_LC_Z) begin
            r.is_letter = 1'b1;
            r.lower     = 1'b1;
            r.idx       = IDX_W'(c - ASCII_LC_A);
        end
        return r;
    endfunction

endpackage

// ===== sv/kwsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// kwsc_ctrl
// Command decode and sequencer for the table fill, inverse and identity sweeps.
// ----------------------------------------------------------------------------
module kwsc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_cmd,
    output kwsc_pkg::dp_cmd_t    dp_cmd,
    input  kwsc_pkg::dp_status_t dp_status
);
    import kwsc_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_FILL   = 2'd1;
    localparam logic [1:0] ST_INVERT = 2'd2;
    localparam logic [1:0] ST_IDENT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    letter_idx_t cnt_reg, cnt_next;
    logic        accept;
    logic        last;

    assign last = (cnt_reg == LAST_IDX);

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        s_ready          = (state_reg == ST_IDLE) && dp_status.out_free;
        accept           = s_valid && s_ready;
        dp_cmd           = '0;
        dp_cmd.sweep_idx = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_cmd)
                        CMD_KEY: begin
                            dp_cmd.key_byte = 1'b1;
                        end
                        CMD_END: begin
                            dp_cmd.end_key = 1'b1;
                            state_next     = dp_status.key_bad ? ST_IDENT : ST_FILL;
                            cnt_next       = '0;
                        end
                        CMD_TEXT: begin
                            dp_cmd.text = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                dp_cmd.fill_step = 1'b1;
                if (last) begin
                    state_next = ST_INVERT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_INVERT: begin
                dp_cmd.inv_step = 1'b1;
                if (last) begin
                    dp_cmd.clear_build = 1'b1;
                    state_next         = ST_IDLE;
                    cnt_next           = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDENT: begin
                dp_cmd.ident_step = 1'b1;
                if (last) begin
                    dp_cmd.clear_build = 1'b1;
                    state_next         = ST_IDLE;
                    cnt_next           = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_end_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_END) |=> !s_ready)
        else $error("input accepted right after end of keyword");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_IDX)
        else $error("sweep counter out of range");

    a_fill_then_invert: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL && last) |=> (state_reg == ST_INVERT && cnt_reg == '0))
        else $error("fill sweep did not hand over to inverse sweep");

endmodule

// ===== sv/kwsc_datapath.sv =====
// ----------------------------------------------------------------------------
// kwsc_datapath
// Cipher tables, keyword build state, mode register and output register.
// ----------------------------------------------------------------------------
module kwsc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_char_value,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  kwsc_pkg::dp_cmd_t    dp_cmd,
    output kwsc_pkg::dp_status_t dp_status,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [7:0]           m_out_char,
    output logic                 m_is_key_status,
    output logic                 m_key_rejected
);
    import kwsc_pkg::*;

    letter_idx_t       fwd_reg [LETTERS];
    letter_idx_t       inv_reg [LETTERS];
    logic [LETTERS-1:0] used_reg, used_next;
    logic [IDX_W:0]    fill_reg, fill_next;
    logic              key_bad_reg, key_bad_next;
    logic              decrypt_reg;

    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    logic              out_status_reg;
    logic              out_rej_reg;

    letter_info_t      ch;
    logic              fill_room;
    logic              fwd_we, inv_we;
    letter_idx_t       fwd_waddr, fwd_wdata, fwd_raddr, fwd_rdata;
    letter_idx_t       inv_waddr, inv_wdata;
    letter_idx_t       map_idx;
    logic [7:0]        text_char;

    assign ch        = letter_decode(s_char_value);
    assign fill_room = (fill_reg < FULL_CNT);
    assign fwd_raddr = dp_cmd.inv_step ? dp_cmd.sweep_idx : ch.idx;
    assign fwd_rdata = fwd_reg[fwd_raddr];
    assign map_idx   = decrypt_reg ? inv_reg[ch.idx] : fwd_rdata;

    always_comb begin
        if (ch.is_letter) begin
            text_char = (ch.lower ? ASCII_LC_A : ASCII_UC_A) + {3'b000, map_idx};
        end else begin
            text_char = s_char_value;
        end
    end

    always_comb begin
        fwd_we       = 1'b0;
        fwd_waddr    = fill_reg[IDX_W-1:0];
        fwd_wdata    = ch.idx;
        used_next    = used_reg;
        fill_next    = fill_reg;
        key_bad_next = key_bad_reg;
        if (dp_cmd.key_byte) begin
            if (!ch.is_letter) begin
                key_bad_next = 1'b1;
            end else if (!used_reg[ch.idx] && fill_room) begin
                fwd_we              = 1'b1;
                used_next[ch.idx]   = 1'b1;
                fill_next           = fill_reg + 1'b1;
            end
        end
        if (dp_cmd.fill_step && !used_reg[dp_cmd.sweep_idx] && fill_room) begin
            fwd_we                      = 1'b1;
            fwd_wdata                   = dp_cmd.sweep_idx;
            used_next[dp_cmd.sweep_idx] = 1'b1;
            fill_next                   = fill_reg + 1'b1;
        end
        if (dp_cmd.ident_step) begin
            fwd_we    = 1'b1;
            fwd_waddr = dp_cmd.sweep_idx;
            fwd_wdata = dp_cmd.sweep_idx;
        end
        if (dp_cmd.clear_build) begin
            used_next    = '0;
            fill_next    = '0;
            key_bad_next = 1'b0;
        end
    end

    assign inv_we    = dp_cmd.inv_step || dp_cmd.ident_step;
    assign inv_waddr = dp_cmd.inv_step ? fwd_rdata : dp_cmd.sweep_idx;
    assign inv_wdata = dp_cmd.sweep_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LETTERS; i++) begin
                fwd_reg[i] <= IDX_W'(i);
                inv_reg[i] <= IDX_W'(i);
            end
        end else begin
            if (fwd_we) begin
                fwd_reg[fwd_waddr] <= fwd_wdata;
            end
            if (inv_we) begin
                inv_reg[inv_waddr] <= inv_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '0;
            fill_reg      <= '0;
            key_bad_reg   <= 1'b0;
            decrypt_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            fill_reg    <= fill_next;
            key_bad_reg <= key_bad_next;
            if (cfg_valid) begin
                decrypt_reg <= cfg_data;
            end
            if (dp_cmd.text || dp_cmd.end_key) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.text) begin
            out_char_reg   <= text_char;
            out_status_reg <= 1'b0;
            out_rej_reg    <= 1'b0;
        end else if (dp_cmd.end_key) begin
            out_char_reg   <= 8'h00;
            out_status_reg <= 1'b1;
            out_rej_reg    <= key_bad_reg;
        end
    end

    assign dp_status.key_bad  = key_bad_reg;
    assign dp_status.out_free = !out_valid_reg || m_ready;

    assign m_valid         = out_valid_reg;
    assign m_out_char      = out_char_reg;
    assign m_is_key_status = out_status_reg;
    assign m_key_rejected  = out_rej_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_CNT)
        else $error("fill count beyond alphabet size");

    a_fill_matches_used: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == fill_reg)
        else $error("fill count disagrees with used letter set");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(dp_cmd.text || dp_cmd.end_key))
        else $error("output register overwritten while stalled");

endmodule

// ===== sv/keyword_substitution_cipher.sv =====
// ----------------------------------------------------------------------------
// keyword_substitution_cipher
// Mixed-alphabet keyword substitution cipher, top level.
//
// Input channel s_*: s_cmd selects keyword byte, end of keyword or text byte;
// s_char_value carries the ASCII byte. Result channel m_*: one transfer per
// text byte (m_out_char) and one per end of keyword (m_is_key_status set,
// m_key_rejected for a keyword that held a non-letter). Keyword bytes and
// the unused command code produce no result.
// cfg_*: writes decrypt_mode (0 encrypt, 1 decrypt); always ready.
// A result is registered and valid in the cycle after its transfer.
// Throughput: keyword and text bytes one per cycle while the output register
// is free. End of keyword occupies the table sequencer for 26 fill steps,
// then 26 inverse-table writes, or 26 identity writes for a rejected key;
// s_ready stays low meanwhile. Each step touches one table entry.
// Reset: tables return to identity, build state clears, mode is encrypt.
// Stall: a result waits in the output register; a new item is taken only in
// the cycle the register is empty or being drained.
// ----------------------------------------------------------------------------
module keyword_substitution_cipher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_char_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_is_key_status,
    output logic       m_key_rejected,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import kwsc_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    kwsc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    kwsc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_char_value    (s_char_value),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .dp_cmd          (dp_cmd),
        .dp_status       (dp_status),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_char      (m_out_char),
        .m_is_key_status (m_is_key_status),
        .m_key_rejected  (m_key_rejected)
    );

endmodule
